@@ src/qtu_pkg.sv @@
// Shared constants, register codes and control types for the Q table update block.
package qtu_pkg;

  // Table geometry.
  localparam int STATE_COUNT  = 256;
  localparam int ACTION_COUNT = 4;
  localparam int DEPTH        = STATE_COUNT * ACTION_COUNT;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int ST_W         = $clog2(STATE_COUNT);
  localparam int AC_W         = $clog2(ACTION_COUNT);
  // The read sequence counts over all actions plus one read of the old entry.
  localparam int KW           = $clog2(ACTION_COUNT + 1);

  // Data widths.
  localparam int Q_W   = 16;
  localparam int FR_W  = 16;
  localparam int P1_W  = 34;
  localparam int P2_W  = 33;
  localparam int P3_W  = 49;
  localparam int SUM_W = 52;
  localparam int RND_W = SUM_W - 32;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_LEARN_RATE = 1'b0;
  localparam logic REG_DISCOUNT   = 1'b1;
  localparam logic [FR_W-1:0] LEARN_RATE_RST = 16'd6554;
  localparam logic [FR_W-1:0] DISCOUNT_RST   = 16'd58982;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [KW-1:0]     rd_sel;
    logic              cap_en;
    logic [KW-1:0]     cap_idx;
    logic              mul_en;
    logic              sum_en;
    logic              wr_en;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
  } qtu_cmd_t;

endpackage

@@ src/q_table_update.sv @@
// Top level of the Q table update block: register port, controller and datapath.
// A request runs through the table reads, a drain step, the products, the sum and the
// write-back, which waits while a previous result is stalled; the next request is taken
// after the write-back. Reads: one per action of the next state plus one of the old entry.
// Reset: synchronous; afterwards a clearing pass writes zero to all DEPTH entries,
// one per cycle, with in_ready low. Register writes are taken throughout.
module q_table_update
  import qtu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            cur_state,
  input  logic [1:0]            taken_action,
  input  logic [7:0]            next_state,
  input  logic signed [Q_W-1:0] reward_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [Q_W-1:0] new_value,
  output logic [1:0]            best_next_action,
  output logic signed [Q_W-1:0] best_next_value
);

  logic [FR_W-1:0] learn_rate;
  logic [FR_W-1:0] discount;
  logic            reg_sel;
  logic            cfg_wr;
  qtu_cmd_t        cmd;

  // Register port decode.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_sel == REG_DISCOUNT) ? PDATA_W'(discount) : PDATA_W'(learn_rate);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LEARN_RATE_RST;
      discount   <= DISCOUNT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LEARN_RATE: learn_rate <= pwdata[FR_W-1:0];
        REG_DISCOUNT:   discount   <= pwdata[FR_W-1:0];
        default:        learn_rate <= learn_rate;
      endcase
    end
  end

  qtu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  qtu_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .learn_rate       (learn_rate),
    .discount         (discount),
    .cur_state        (cur_state),
    .taken_action     (taken_action),
    .next_state       (next_state),
    .reward_in        (reward_in),
    .new_value        (new_value),
    .best_next_action (best_next_action),
    .best_next_value  (best_next_value)
  );

endmodule

@@ src/qtu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module qtu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/qtu_ctrl.sv @@
// Controller state machine: clearing pass, read sequence, arithmetic steps and write-back.
module qtu_ctrl
  import qtu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output qtu_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_MUL,
    S_SUM,
    S_WRITE
  } state_t;

  state_t            state;
  logic [KW-1:0]     k;
  logic [ADDR_W-1:0] clr_addr;
  logic              cap_en;
  logic [KW-1:0]     cap_idx;
  logic              accept;
  logic              wr_go;

  // Handshake decode.
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // The write-back waits until the output register is free or being emptied.
  assign wr_go    = (state == S_WRITE) && (!out_valid || out_ready);

  // Command decode for the datapath.
  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.rd_en    = (state == S_READ);
    cmd.rd_sel   = k;
    cmd.cap_en   = cap_en;
    cmd.cap_idx  = cap_idx;
    cmd.mul_en   = (state == S_MUL);
    cmd.sum_en   = (state == S_SUM);
    cmd.wr_en    = wr_go;
    cmd.clr_en   = (state == S_CLEAR);
    cmd.clr_addr = clr_addr;
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      k         <= '0;
      clr_addr  <= '0;
      cap_en    <= 1'b0;
      cap_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Read data returns in the cycle after the address.
      cap_en  <= (state == S_READ);
      cap_idx <= k;

      if (wr_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            k     <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          k <= k + KW'(1);
          if (32'(k) == ACTION_COUNT) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (wr_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/qtu_dp.sv @@
// Datapath: Q table memory, maximum search, blend arithmetic and result register.
module qtu_dp
  import qtu_pkg::*;
(
  input  logic                   clk,
  input  qtu_cmd_t               cmd,
  input  logic [FR_W-1:0]        learn_rate,
  input  logic [FR_W-1:0]        discount,
  input  logic [7:0]             cur_state,
  input  logic [1:0]             taken_action,
  input  logic [7:0]             next_state,
  input  logic signed [Q_W-1:0]  reward_in,
  output logic signed [Q_W-1:0]  new_value,
  output logic [1:0]             best_next_action,
  output logic signed [Q_W-1:0]  best_next_value
);

  localparam logic signed [RND_W-1:0] Q_MAX = RND_W'(32767);
  localparam logic signed [RND_W-1:0] Q_MIN = -RND_W'(32768);

  // Latched request.
  logic [ST_W-1:0]        s_r;
  logic [AC_W-1:0]        a_r;
  logic [ST_W-1:0]        ns_r;
  logic signed [Q_W-1:0]  reward_r;
  logic [FR_W-1:0]        alpha_r;
  logic [FR_W:0]          oma_r;
  logic [2*FR_W-1:0]      ag_r;

  // Values gathered from the table.
  logic signed [Q_W-1:0]  max_q;
  logic [AC_W-1:0]        best;
  logic signed [Q_W-1:0]  old_q;

  // Products, rounded result.
  logic signed [P1_W-1:0] p1;
  logic signed [P2_W-1:0] p2;
  logic signed [P3_W-1:0] p3;
  logic signed [Q_W-1:0]  nv;
  logic signed [SUM_W-1:0] sum_w;
  logic signed [RND_W-1:0] rnd;
  logic signed [Q_W-1:0]  sat_q;

  // Memory interface.
  logic [ADDR_W-1:0]      cur_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic [Q_W-1:0]         wr_data;
  logic [Q_W-1:0]         rd_data;
  logic signed [Q_W-1:0]  rd_q;

  // Address of the entry being updated, and the read address of each step.
  // The step after the last action reads the old entry.
  assign cur_addr = ADDR_W'(32'(s_r) * ACTION_COUNT + 32'(a_r));
  assign rd_addr  = (32'(cmd.rd_sel) == ACTION_COUNT) ? cur_addr
                  : ADDR_W'(32'(ns_r) * ACTION_COUNT + 32'(cmd.rd_sel));
  assign wr_addr  = cmd.clr_en ? cmd.clr_addr : cur_addr;
  assign wr_data  = cmd.clr_en ? '0 : nv;
  assign rd_q     = rd_data;

  qtu_ram #(
    .WIDTH (Q_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en || cmd.clr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Latch the request with out-of-range indexes saturated, and the blend factors.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r      <= (32'(cur_state) >= STATE_COUNT) ? ST_W'(STATE_COUNT - 1) : ST_W'(cur_state);
      ns_r     <= (32'(next_state) >= STATE_COUNT) ? ST_W'(STATE_COUNT - 1) : ST_W'(next_state);
      a_r      <= (32'(taken_action) >= ACTION_COUNT) ? AC_W'(ACTION_COUNT - 1)
                                                      : AC_W'(taken_action);
      reward_r <= reward_in;
      alpha_r  <= learn_rate;
      oma_r    <= (FR_W + 1)'(1 << FR_W) - (FR_W + 1)'(learn_rate);
      ag_r     <= learn_rate * discount;
    end
  end

  // Running maximum over the next state's actions; ties keep the lower index.
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      if (cmd.cap_idx == '0) begin
        max_q <= rd_q;
        best  <= '0;
      end else if (32'(cmd.cap_idx) < ACTION_COUNT) begin
        if (rd_q > max_q) begin
          max_q <= rd_q;
          best  <= AC_W'(cmd.cap_idx);
        end
      end else begin
        old_q <= rd_q;
      end
    end
  end

  // Three products: (1 - alpha) * old, alpha * reward, alpha * gamma * max.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p1 <= $signed({1'b0, oma_r}) * old_q;
      p2 <= $signed({1'b0, alpha_r}) * reward_r;
      p3 <= $signed({1'b0, ag_r}) * max_q;
    end
  end

  // Sum at Q.40, round half up to Q8.8 and saturate.
  always_comb begin
    sum_w = ((SUM_W'(p1) + SUM_W'(p2)) <<< 16) + SUM_W'(p3) + (SUM_W'(1) <<< 31);
    rnd   = sum_w[SUM_W-1:32];
    if (rnd > Q_MAX) begin
      sat_q = Q_W'(Q_MAX);
    end else if (rnd < Q_MIN) begin
      sat_q = Q_W'(Q_MIN);
    end else begin
      sat_q = Q_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      nv <= sat_q;
    end
  end

  // Result register, loaded together with the write-back.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      new_value        <= nv;
      best_next_action <= 2'(32'(best));
      best_next_value  <= max_q;
    end
  end

endmodule

@@ src/qtu_checker.sv @@
// Port-level checks for the Q table update block, bound to the top level.
module qtu_checker
  import qtu_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [PADDR_W-1:0]    paddr,
  input logic [PDATA_W-1:0]    pwdata,
  input logic [PDATA_W-1:0]    prdata,
  input logic                  pready,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [7:0]            cur_state,
  input logic [1:0]            taken_action,
  input logic [7:0]            next_state,
  input logic signed [Q_W-1:0] reward_in,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [Q_W-1:0] new_value,
  input logic [1:0]            best_next_action,
  input logic signed [Q_W-1:0] best_next_value
);

  // Reset starts the clearing pass with no request taken and no result shown.
  a_reset_clears: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("request or result visible right after reset");

  // One request at a time: the block is busy in the cycle after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request port ready right after an acceptance");

  // A new result appears only at the end of work, never out of the idle state.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_value)
      && $stable(best_next_action) && $stable(best_next_value))
    else $error("stalled result changed");

endmodule

bind q_table_update qtu_checker u_qtu_checker (.*);
